[rtl/rfpf_pkg.sv]
`default_nettype none
package rfpf_pkg;

	// Operation codes of an input item.
	localparam logic OP_SEND   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Kind codes of a result item.
	localparam logic KIND_CMD = 1'b0;
	localparam logic KIND_BIT = 1'b1;

	// Module command words.
	localparam logic [15:0] CMD_AMP_OFF    = 16'hC037;
	localparam logic [15:0] CMD_AMP_ON     = 16'hC03F;
	localparam logic [15:0] CMD_POWER_DOWN = 16'hC033;

	// Frame bytes.
	localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
	localparam logic [7:0] SYNC_HI_BYTE  = 8'h2D;
	localparam logic [7:0] SYNC_LO_BYTE  = 8'hD4;
	localparam logic [7:0] LABEL_MAX     = 8'd15;

	localparam int unsigned FRAME_LEN = 64;
	localparam int unsigned CNT_W     = 7;

	// Result queue.
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic        kind;
		logic [15:0] command_word;
		logic        fsk_bit;
		logic        last;
	} result_t;

	// Results handed from the framer stage to the queue in one cycle.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	// Queue status seen by the framer.
	typedef struct packed {
		logic [QCNT_W-1:0] fill;
	} qstat_t;

endpackage
`default_nettype wire

[rtl/rfpf_in_if.sv]
`default_nettype none
interface rfpf_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] label;
	logic [7:0] value;
	logic       irq_level;

	modport source (output valid, operation, label, value, irq_level, input ready);
	modport sink (input valid, operation, label, value, irq_level, output ready);
endinterface
`default_nettype wire

[rtl/rfpf_out_if.sv]
`default_nettype none
interface rfpf_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] command_word;
	logic        fsk_bit;
	logic        last;

	modport source (output valid, kind, command_word, fsk_bit, last, input ready);
	modport sink (input valid, kind, command_word, fsk_bit, last, output ready);
endinterface
`default_nettype wire

[rtl/rfpf_res_fifo.sv]
`default_nettype none
// Small result queue that takes up to two results per cycle and gives one.
module rfpf_res_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rfpf_pkg::push_t push,
	output rfpf_pkg::qstat_t    stat,
	rfpf_out_if.source          result
);

	rfpf_pkg::result_t mem_q [rfpf_pkg::QDEPTH];
	logic [rfpf_pkg::QPTR_W-1:0] wr_q;
	logic [rfpf_pkg::QPTR_W-1:0] rd_q;
	logic [rfpf_pkg::QCNT_W-1:0] fill_q;
	logic pop;
	rfpf_pkg::result_t head;

	assign pop  = result.valid && result.ready;
	assign head = mem_q[rd_q];

	assign result.valid        = (fill_q != '0);
	assign result.kind         = head.kind;
	assign result.command_word = head.command_word;
	assign result.fsk_bit      = head.fsk_bit;
	assign result.last         = head.last;
	assign stat.fill           = fill_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + rfpf_pkg::QPTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + rfpf_pkg::QPTR_W'(push.n);
			rd_q   <= rd_q + rfpf_pkg::QPTR_W'(pop);
			fill_q <= fill_q + rfpf_pkg::QCNT_W'(push.n) - rfpf_pkg::QCNT_W'(pop);
		end
	end

	// The queue never overflows.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(5'(fill_q) + 5'(push.n)) <= 5'(rfpf_pkg::QDEPTH))
		else $error("result queue overflow");

	// A result is only shown when something was stored.
	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 && push.n == 2'd0) |=> !result.valid)
		else $error("result shown from an empty queue");

	// Two results pushed while nothing is taken raise the fill by two.
	a_fill_two: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2 && !pop) |=> fill_q == $past(fill_q) + rfpf_pkg::QCNT_W'(2))
		else $error("fill count lost a pushed result");

endmodule
`default_nettype wire

[rtl/rf_packet_framer_checksum_core.sv]
`default_nettype none
// Packet framer for an FSK radio transmitter.
//
// Channel "item" carries either a send request (operation 0, label, value)
// or a sample of the transmitter's bit-clock pin (operation 1, irq_level).
// Channel "result" carries command words for the radio module (kind 0) and
// FSK data bits (kind 1); last marks the final result caused by one item.
//
// A send request from idle emits the amplifier-off and amplifier-on command
// words and loads the eight-byte frame. Each falling pin edge that follows a
// high sample sends the next frame bit, most significant first; after the
// 64th bit a power-down command word follows. Requests while busy and pin
// samples while idle give no result.
// An accepted item is held in an input register; the framer logic then writes
// zero, one or two results into an eight-entry queue with a registered fill
// count, so a result passes the input register and the queue register before
// it is valid. An item is accepted every cycle while the queue holds
// room for the results of the item in flight and of the new one; as the queue
// gives one result per cycle, items that cause two results each cannot keep
// that rate. A stalled receiver fills the queue and drops ready;
// nothing is lost. Reset clears the framer to idle and empties the queue.
module rf_packet_framer_checksum_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rfpf_in_if.sink     item,
	rfpf_out_if.source  result
);

	// Input register.
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] label_s1;
	logic [7:0] value_s1;
	logic       level_s1;

	// Framer state.
	logic                          busy_q;
	logic [rfpf_pkg::FRAME_LEN-1:0] frame_q;
	logic [rfpf_pkg::CNT_W-1:0]     count_q;
	logic                          seen_high_q;

	rfpf_pkg::push_t  push;
	rfpf_pkg::qstat_t stat;
	logic             accept;

	// Room is checked against the worst case: the item in the input register
	// and the new one may each add two results.
	assign item.ready = (5'(stat.fill) + (valid_s1 ? 5'd2 : 5'd0))
		<= 5'(rfpf_pkg::QDEPTH - 2);
	assign accept = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= item.operation;
			label_s1 <= item.label;
			value_s1 <= item.value;
			level_s1 <= item.irq_level;
		end
	end

	// Framer logic between the input register and the result queue.
	logic [3:0]                    lab4;
	logic [3:0]                    chk;
	logic [rfpf_pkg::FRAME_LEN-1:0] new_frame;
	logic [rfpf_pkg::CNT_W-1:0]     count_inc;
	logic                          do_load;
	logic                          do_bit;
	logic                          do_seen;
	logic                          done;
	rfpf_pkg::result_t             res_a;
	rfpf_pkg::result_t             res_b;

	always_comb begin
		// A label above the limit is sent as zero.
		lab4 = (label_s1 > rfpf_pkg::LABEL_MAX) ? 4'd0 : label_s1[3:0];
		chk  = value_s1[7:4] ^ value_s1[3:0] ^ lab4;
		new_frame = {rfpf_pkg::PREAMBLE_BYTE, rfpf_pkg::PREAMBLE_BYTE,
			rfpf_pkg::PREAMBLE_BYTE, rfpf_pkg::SYNC_HI_BYTE, rfpf_pkg::SYNC_LO_BYTE,
			chk, lab4, value_s1, rfpf_pkg::PREAMBLE_BYTE};
		count_inc = count_q + rfpf_pkg::CNT_W'(1);

		do_load = valid_s1 && (op_s1 == rfpf_pkg::OP_SEND) && !busy_q;
		do_seen = valid_s1 && (op_s1 == rfpf_pkg::OP_SAMPLE) && busy_q && level_s1;
		do_bit  = valid_s1 && (op_s1 == rfpf_pkg::OP_SAMPLE) && busy_q && !level_s1
			&& seen_high_q;
		done    = (count_inc == rfpf_pkg::CNT_W'(rfpf_pkg::FRAME_LEN));

		res_a = '0;
		res_b = '0;
		push.n = 2'd0;
		if (do_load) begin
			res_a.kind         = rfpf_pkg::KIND_CMD;
			res_a.command_word = rfpf_pkg::CMD_AMP_OFF;
			res_b.kind         = rfpf_pkg::KIND_CMD;
			res_b.command_word = rfpf_pkg::CMD_AMP_ON;
			res_b.last         = 1'b1;
			push.n = 2'd2;
		end else if (do_bit) begin
			res_a.kind    = rfpf_pkg::KIND_BIT;
			res_a.fsk_bit = frame_q[rfpf_pkg::FRAME_LEN-1];
			if (done) begin
				// The frame's final bit is followed by the power-down command.
				res_b.kind         = rfpf_pkg::KIND_CMD;
				res_b.command_word = rfpf_pkg::CMD_POWER_DOWN;
				res_b.last         = 1'b1;
				push.n = 2'd2;
			end else begin
				res_a.last = 1'b1;
				push.n = 2'd1;
			end
		end
		push.r0 = res_a;
		push.r1 = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			frame_q     <= '0;
			count_q     <= '0;
			seen_high_q <= 1'b0;
		end else begin
			if (do_load) begin
				busy_q      <= 1'b1;
				frame_q     <= new_frame;
				count_q     <= '0;
				seen_high_q <= 1'b0;
			end else if (do_seen) begin
				seen_high_q <= 1'b1;
			end else if (do_bit) begin
				frame_q     <= {frame_q[rfpf_pkg::FRAME_LEN-2:0], 1'b0};
				count_q     <= count_inc;
				seen_high_q <= 1'b0;
				if (done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	rfpf_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.stat   (stat),
		.result (result)
	);

	// While busy, fewer than a whole frame of bits has gone out.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (count_q < rfpf_pkg::CNT_W'(rfpf_pkg::FRAME_LEN)))
		else $error("bit count past frame end while busy");

	// A request from idle starts a fresh frame.
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		do_load |=> (busy_q && count_q == '0 && !seen_high_q))
		else $error("send request did not start a frame");

	// A bit is only sent after the pin was seen high.
	a_bit_needs_high: assert property (@(posedge clk) disable iff (!arst_n)
		do_bit |-> seen_high_q)
		else $error("frame bit sent without a prior high sample");

endmodule
`default_nettype wire
